// ===== rtl/ansi_text_terminal_engine_unit_defines.svh =====
// Assertion macros used by the port-level checker.
`ifndef ANSI_TEXT_TERMINAL_ENGINE_UNIT_DEFINES_SVH
`define ANSI_TEXT_TERMINAL_ENGINE_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ATT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ATT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/att_pkg.sv =====
// Shared types, constants and functions for the text terminal engine.
`default_nettype none
package att_pkg;
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF = 25;
	localparam int TERMINALS_DEF = 4;

	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] LBRACKET = 8'h5B;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_J = 8'h4A;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] BG_MASK = 8'hF0;
	localparam logic [7:0] DEFAULT_ATTR = 8'h07;
	localparam logic [15:0] SGR_FG_LOW = 16'd30;
	localparam logic [15:0] SGR_FG_HIGH = 16'd37;
	localparam logic [15:0] PARAM_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		PS_NORMAL = 3'd0,
		PS_ESC = 3'd1,
		PS_BRACKET = 3'd2,
		PS_FIRST = 3'd3,
		PS_SECOND = 3'd4
	} parse_state_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] terminal;
		logic [7:0] char_byte;
		logic [4:0] row;
		logic [6:0] column;
		logic       last_of_write;
	} in_item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [4:0] cursor_row;
		logic [6:0] cursor_column;
		logic [7:0] current_colour;
		logic [2:0] escape_state;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,     // sweep of whole store after reset
		ST_IDLE,
		ST_DECODE,    // registered item examined, per-terminal state updated
		ST_READ,      // wait for memory read data
		ST_SCR_RD,    // scroll: read source cell
		ST_SCR_WR,    // scroll: write it one row up
		ST_FILL,      // blank a range of cells
		ST_OUT        // result held until taken
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic decode;
		logic rd_issue;
		logic capture_read;
		logic scr_rd;
		logic scr_wr;
		logic fill_wr;
		logic clr_wr;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_read;
		logic need_scroll;
		logic need_clear;
		logic scr_last;
		logic fill_last;
		logic clr_last;
	} dp_status_t;

	function automatic logic [2:0] fg_map(input logic [2:0] i);
		logic [2:0] r;
		unique case (i)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] acc_digit(input logic [15:0] p, input logic [3:0] d);
		logic [19:0] v;
		v = {p, 3'b000} + {3'b000, p, 1'b0} + {16'd0, d};
		return (v > {4'd0, PARAM_MAX}) ? PARAM_MAX : v[15:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/att_ram.sv =====
// Generic RAM with one write port and one registered read port.
`default_nettype none
module att_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/att_ctrl.sv =====
// Controller state machine sequencing reads, scrolls, fills and the clear sweep.
`default_nettype none
module att_ctrl
	import att_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output logic            in_ready,
	output logic            out_valid,
	output ctrl_cmd_t       cmd
);
	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (status.clr_last) state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				priority if (status.need_read) state_d = ST_READ;
				else if (status.need_clear) state_d = ST_FILL;
				else if (status.need_scroll) state_d = ST_SCR_RD;
				else state_d = ST_OUT;
			end
			ST_READ: state_d = ST_OUT;
			ST_SCR_RD: state_d = ST_SCR_WR;
			ST_SCR_WR: state_d = status.scr_last ? ST_FILL : ST_SCR_RD;
			ST_FILL: if (status.fill_last) state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				cmd.rd_issue = status.need_read;
			end
			ST_READ: cmd.capture_read = 1'b1;
			ST_SCR_RD: cmd.scr_rd = 1'b1;
			ST_SCR_WR: cmd.scr_wr = 1'b1;
			ST_FILL: cmd.fill_wr = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/att_dp.sv =====
// Datapath: per-terminal registers, escape parser, screen store and sweep counters.
`default_nettype none
module att_dp
	import att_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	parameter int TERMINALS = TERMINALS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire in_item_t   in_item,
	input  wire ctrl_cmd_t  cmd,
	output dp_status_t      status,
	output out_item_t       out_item
);
	localparam int CELLS = ROWS * COLUMNS;
	localparam int DEPTH = TERMINALS * CELLS;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = (CELLS > 1) ? $clog2(CELLS + 1) : 1;
	localparam int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
	localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);
	localparam logic [6:0] LAST_COL = 7'(COLUMNS - 1);

	logic [4:0]  crow_q [TERMINALS];
	logic [6:0]  ccol_q [TERMINALS];
	logic [7:0]  attr_q [TERMINALS];
	logic [2:0]  pst_q  [TERMINALS];
	logic [15:0] p1_q   [TERMINALS];
	logic [15:0] p2_q   [TERMINALS];

	in_item_t  item_q;
	logic      t_ok;
	logic [TW-1:0] t;
	logic [AW-1:0] base;

	// Cell address = base + row*COLUMNS + col
	logic [AW-1:0] cell_addr_rd;
	logic [CW-1:0] off_q;        // scroll/fill/clear offset within a screen
	logic [CW-1:0] fill_end_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    fill_attr_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata, rdata;

	assign t_ok = ({30'd0, item_q.terminal} < 32'(TERMINALS));
	assign t = TW'(item_q.terminal);
	assign base = AW'(32'(t) * CELLS);
	assign cell_addr_rd = base + AW'(32'(item_q.row) * COLUMNS) + AW'(item_q.column);

	// Parser decode, combinational on the registered item.
	logic [4:0] r0, r1, nr;
	logic [6:0] c0, c1, nc;
	logic [7:0] a0, na;
	logic [2:0] ps, nps;
	logic [15:0] np1, np2;
	logic       cell_we;
	logic [4:0] cw_r;
	logic [6:0] cw_c;
	logic [15:0] cw_d;
	logic       do_put, do_clear, do_scroll;
	logic [7:0] ch;
	logic [15:0] xh, yh;

	always_comb begin
		r0 = crow_q[t]; c0 = ccol_q[t]; a0 = attr_q[t]; ps = pst_q[t];
		ch = item_q.char_byte;
		nr = r0; nc = c0; na = a0; nps = ps; np1 = p1_q[t]; np2 = p2_q[t];
		cell_we = 1'b0; cw_r = r0; cw_c = c0; cw_d = {a0, ch};
		do_put = 1'b0; do_clear = 1'b0; do_scroll = 1'b0;
		r1 = r0; c1 = c0;
		xh = '0; yh = '0;
		if (item_q.kind == 1'b0 && t_ok) begin
			priority if (ps == PS_NORMAL) begin
				if (ch == ESC_BYTE) begin
					nps = PS_ESC; np1 = '0; np2 = '0;
				end else
					do_put = 1'b1;
			end else if (ps == PS_ESC) begin
				nps = (ch == LBRACKET) ? PS_BRACKET : PS_NORMAL;
				do_put = (ch != LBRACKET);
			end else if (ps <= PS_SECOND) begin
				if (ch >= 8'h30 && ch <= 8'h39) begin
					if (ps == PS_BRACKET || ps == PS_FIRST) begin
						nps = PS_FIRST; np1 = acc_digit(p1_q[t], ch[3:0]);
					end else
						np2 = acc_digit(p2_q[t], ch[3:0]);
				end else if (ch == CH_SEMI)
					nps = PS_SECOND;
				else begin
					nps = PS_NORMAL;
					if (ch == CH_M) begin
						if (p1_q[t] == 16'd0)
							na = DEFAULT_ATTR;
						else if (p1_q[t] >= SGR_FG_LOW && p1_q[t] <= SGR_FG_HIGH)
							na = (a0 & BG_MASK) | {5'd0, fg_map(3'(p1_q[t] - SGR_FG_LOW))};
					end else if (ch == CH_J) begin
						if (p1_q[t] == 16'd2) begin
							do_clear = 1'b1; nr = '0; nc = '0;
						end
					end else if (ch == CH_H) begin
						xh = (p2_q[t] != 0) ? p2_q[t] - 16'd1 : 16'd0;
						yh = (p1_q[t] != 0) ? p1_q[t] - 16'd1 : 16'd0;
						nc = (xh > 16'(LAST_COL)) ? LAST_COL : xh[6:0];
						nr = (yh > 16'(LAST_ROW)) ? LAST_ROW : yh[4:0];
					end
				end
			end else begin
				nps = ps;
			end
			if (do_put) begin
				priority if (ch == CH_NL) begin
					c1 = '0; r1 = r0 + 5'd1;
				end else if (ch == CH_BS) begin
					if (c0 != 0)
						c1 = c0 - 7'd1;
					else if (r0 != 0) begin
						r1 = r0 - 5'd1; c1 = LAST_COL;
					end
					cell_we = 1'b1; cw_r = r1; cw_c = c1; cw_d = {a0, CH_SPACE};
				end else if (ch == CH_CR)
					c1 = '0;
				else begin
					cell_we = 1'b1; c1 = c0 + 7'd1;
				end
				if (c1 >= 7'(COLUMNS)) begin
					c1 = '0; r1 = r1 + 5'd1;
				end
				nr = r1; nc = c1;
				if (r1 >= 5'(ROWS)) begin
					do_scroll = 1'b1; nr = LAST_ROW;
				end
				if (cw_r >= 5'(ROWS) || cw_c >= 7'(COLUMNS))
					cell_we = 1'b0;
			end
		end
	end

	assign status.need_read = item_q.kind && t_ok && (item_q.row < 5'(ROWS))
		&& (item_q.column < 7'(COLUMNS));
	assign status.need_scroll = do_scroll;
	assign status.need_clear = do_clear;
	assign status.scr_last = (off_q == CW'(CELLS - COLUMNS - 1));
	assign status.fill_last = (off_q == fill_end_q);
	assign status.clr_last = (clr_q == AW'(DEPTH - 1));

	// Memory port selection.
	always_comb begin
		we = 1'b0; waddr = '0; wdata = '0; raddr = cell_addr_rd;
		if (cmd.clr_wr) begin
			we = 1'b1; waddr = clr_q; wdata = {DEFAULT_ATTR, CH_SPACE};
		end else if (cmd.decode) begin
			we = cell_we;
			waddr = base + AW'(32'(cw_r) * COLUMNS) + AW'(cw_c);
			wdata = cw_d;
		end else if (cmd.scr_rd)
			raddr = base + AW'(off_q) + AW'(COLUMNS);
		else if (cmd.scr_wr) begin
			we = 1'b1; waddr = base + AW'(off_q); wdata = rdata;
		end else if (cmd.fill_wr) begin
			we = 1'b1; waddr = base + AW'(off_q); wdata = {fill_attr_q, CH_SPACE};
		end
	end

	att_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TERMINALS; i++) begin
				crow_q[i] <= '0; ccol_q[i] <= '0; attr_q[i] <= DEFAULT_ATTR;
				pst_q[i] <= '0; p1_q[i] <= '0; p2_q[i] <= '0;
			end
			clr_q <= '0;
		end else begin
			if (cmd.clr_wr)
				clr_q <= clr_q + AW'(1);
			if (cmd.decode && t_ok && !item_q.kind) begin
				crow_q[t] <= nr; ccol_q[t] <= nc; attr_q[t] <= na;
				pst_q[t] <= nps; p1_q[t] <= np1; p2_q[t] <= np2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= in_item;
		if (cmd.decode) begin
			fill_attr_q <= a0;
			if (do_clear) begin
				off_q <= '0; fill_end_q <= CW'(CELLS - 1);
			end else if (do_scroll) begin
				off_q <= '0; fill_end_q <= CW'(CELLS - 1);
			end
			out_item.cell_char <= '0;
			out_item.cell_attr <= '0;
			out_item.cursor_row <= t_ok ? nr : '0;
			out_item.cursor_column <= t_ok ? nc : '0;
			out_item.current_colour <= t_ok ? na : '0;
			out_item.escape_state <= t_ok ? nps : '0;
		end
		if (cmd.scr_wr)
			off_q <= off_q + CW'(1);
		if (cmd.fill_wr)
			off_q <= off_q + CW'(1);
		if (cmd.capture_read) begin
			out_item.cell_char <= rdata[7:0];
			out_item.cell_attr <= rdata[15:8];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ansi_text_terminal_engine_unit.sv =====
// Sequence: a feed passes the load, decode and result states, a read adds a RAM read state;
// a clear also blanks every cell of the screen, a scroll copies each cell one row up with a
// read and a write per cell through the single RAM port pair, then blanks the last row.
// Throughput: one item at a time; next item accepted the cycle after the result is taken.
// Reset: arst_n clears control at once, then a sweep over all TERMINALS*ROWS*COLUMNS cells
// blanks the screen store; no item is accepted until it ends.
`default_nettype none
module ansi_text_terminal_engine_unit
	import att_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	parameter int TERMINALS = TERMINALS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	ctrl_cmd_t  cmd;
	dp_status_t status;

	att_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .out_ready(out_ready),
		.status(status), .in_ready(in_ready), .out_valid(out_valid), .cmd(cmd)
	);

	att_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TERMINALS(TERMINALS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd),
		.status(status), .out_item(out_data)
	);
endmodule
`default_nettype wire

// ===== rtl/att_checker.sv =====
// Port-level checker for the terminal engine, bound to the top level.
`default_nettype none
`include "ansi_text_terminal_engine_unit_defines.svh"
module att_checker
	import att_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);
	// one item in flight: no input taken while a result is pending
	`ATT_ASSERT_IMPL(a_excl, out_valid, !in_ready)
	// a pending result holds until taken
	`ATT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// parser state never leaves its legal range
	`ATT_ASSERT_IMPL(a_esc, out_valid, out_data.escape_state <= 3'd4)
	// an accepted input is followed by no immediate acceptance
	`ATT_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
endmodule

bind ansi_text_terminal_engine_unit att_checker u_att_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ===== test/ansi_text_terminal_engine_unit_tb.sv =====
// Testbench for the text terminal engine: random and directed traffic against a screen model.
`default_nettype none
module ansi_text_terminal_engine_unit_tb;
	import att_pkg::*;

	localparam int COLS = COLUMNS_DEF;
	localparam int ROWN = ROWS_DEF;
	localparam int TERMS = TERMINALS_DEF;
	localparam int CELLS = COLS * ROWN;
	localparam longint CYCLE_LIMIT = 64'd40_000_000;

	class screen_scoreboard;
		logic [15:0] cells [TERMS*CELLS];
		logic [4:0] crow [TERMS];
		logic [6:0] ccol [TERMS];
		logic [7:0] attr [TERMS];
		parse_state_t pstate [TERMS];
		logic [15:0] p1 [TERMS];
		logic [15:0] p2 [TERMS];
		out_item_t pending [$];
		int errors;

		function void reset_all();
			for (int t = 0; t < TERMS; t++) begin
				attr[t] = DEFAULT_ATTR;
				clear_term(t);
				pstate[t] = PS_NORMAL;
				p1[t] = 0;
				p2[t] = 0;
			end
			errors = 0;
		endfunction

		function logic [15:0] blank(int t);
			return {attr[t], CH_SPACE};
		endfunction

		function void clear_term(int t);
			for (int i = 0; i < CELLS; i++)
				cells[t*CELLS+i] = blank(t);
			crow[t] = 0;
			ccol[t] = 0;
		endfunction

		function void scroll_term(int t);
			for (int i = 0; i + COLS < CELLS; i++)
				cells[t*CELLS+i] = cells[t*CELLS+i+COLS];
			for (int i = 0; i < COLS; i++)
				cells[t*CELLS+(ROWN-1)*COLS+i] = blank(t);
			crow[t] = ROWN - 1;
		endfunction

		function logic [15:0] digit_sat(logic [15:0] p, int d);
			int unsigned v;
			v = p * 10 + d;
			return (v > 65535) ? 16'hFFFF : v[15:0];
		endfunction

		function void write_char(int t, logic [7:0] ch);
			int r;
			int c;
			r = crow[t];
			c = ccol[t];
			if (ch == CH_NL) begin
				c = 0;
				r++;
			end else if (ch == CH_BS) begin
				if (c > 0) c--;
				else if (r > 0) begin
					r--;
					c = COLS - 1;
				end
				cells[t*CELLS+r*COLS+c] = blank(t);
			end else if (ch == CH_CR) begin
				c = 0;
			end else begin
				cells[t*CELLS+r*COLS+c] = {attr[t], ch};
				c++;
			end
			if (c >= COLS) begin
				c = 0;
				r++;
			end
			crow[t] = (r >= ROWN) ? 5'(ROWN) : 5'(r);
			ccol[t] = 7'(c);
			if (r >= ROWN) scroll_term(t);
		endfunction

		function void run_parser(int t, logic [7:0] ch);
			int x;
			int y;
			case (pstate[t])
				PS_NORMAL: begin
					if (ch == ESC_BYTE) begin
						pstate[t] = PS_ESC;
						p1[t] = 0;
						p2[t] = 0;
					end else write_char(t, ch);
				end
				PS_ESC: begin
					if (ch == LBRACKET) pstate[t] = PS_BRACKET;
					else begin
						pstate[t] = PS_NORMAL;
						write_char(t, ch);
					end
				end
				default: begin
					if (ch >= 8'h30 && ch <= 8'h39) begin
						if (pstate[t] == PS_BRACKET) pstate[t] = PS_FIRST;
						if (pstate[t] == PS_FIRST) p1[t] = digit_sat(p1[t], ch - 8'h30);
						else p2[t] = digit_sat(p2[t], ch - 8'h30);
					end else if (ch == CH_SEMI) begin
						pstate[t] = PS_SECOND;
					end else begin
						if (ch == CH_M) begin
							if (p1[t] == 0) attr[t] = DEFAULT_ATTR;
							else if (p1[t] >= SGR_FG_LOW && p1[t] <= SGR_FG_HIGH) begin
								case (3'(p1[t] - SGR_FG_LOW))
									3'd0: x = 0; 3'd1: x = 4; 3'd2: x = 2; 3'd3: x = 6;
									3'd4: x = 1; 3'd5: x = 5; 3'd6: x = 3; default: x = 7;
								endcase
								attr[t] = (attr[t] & BG_MASK) | 8'(x);
							end
						end else if (ch == CH_J) begin
							if (p1[t] == 2) clear_term(t);
						end else if (ch == CH_H) begin
							x = (p2[t] > 0) ? p2[t] - 1 : 0;
							y = (p1[t] > 0) ? p1[t] - 1 : 0;
							if (x >= COLS) x = COLS - 1;
							if (y >= ROWN) y = ROWN - 1;
							ccol[t] = 7'(x);
							crow[t] = 5'(y);
						end
						pstate[t] = PS_NORMAL;
					end
				end
			endcase
		endfunction

		function void note_input(in_item_t it);
			out_item_t o;
			int t;
			o = '0;
			t = it.terminal;
			if (it.kind == 1'b0) run_parser(t, it.char_byte);
			else if (it.row < ROWN && it.column < COLS) begin
				o.cell_char = cells[t*CELLS+it.row*COLS+it.column][7:0];
				o.cell_attr = cells[t*CELLS+it.row*COLS+it.column][15:8];
			end
			o.cursor_row = crow[t];
			o.cursor_column = ccol[t];
			o.current_colour = attr[t];
			o.escape_state = pstate[t];
			pending.push_back(o);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t w;
			if (pending.size() == 0) begin
				report("unexpected result", 32'(got), 32'd0);
			end else begin
				w = pending.pop_front();
				if (got.cell_char !== w.cell_char) report("cell_char", got.cell_char, w.cell_char);
				if (got.cell_attr !== w.cell_attr) report("cell_attr", got.cell_attr, w.cell_attr);
				if (got.cursor_row !== w.cursor_row)
					report("cursor_row", got.cursor_row, w.cursor_row);
				if (got.cursor_column !== w.cursor_column)
					report("cursor_column", got.cursor_column, w.cursor_column);
				if (got.current_colour !== w.current_colour)
					report("current_colour", got.current_colour, w.current_colour);
				if (got.escape_state !== w.escape_state)
					report("escape_state", got.escape_state, w.escape_state);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	longint cycles;
	bit calm;
	screen_scoreboard board;

	ansi_text_terminal_engine_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Input accepted / result taken, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_input(in_data);
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
	end

	// Receiver stalls, with a quiet stretch in the middle.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			out_ready <= calm || ($urandom_range(99) >= 12);
		end
	end

	// Called at a falling edge; valid drops only for an idle gap or at the end.
	task send(in_item_t it);
		if (!calm)
			while ($urandom_range(99) < 12) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task feed(int t, logic [7:0] ch);
		in_item_t it;
		it = '0;
		it.terminal = 2'(t);
		it.char_byte = ch;
		it.last_of_write = 1'($urandom_range(1));
		send(it);
	endtask

	task feed_text(int t, string s);
		for (int i = 0; i < s.len(); i++) feed(t, s[i]);
	endtask

	task read_cell(int t, int r, int c);
		in_item_t it;
		it = '0;
		it.kind = 1'b1;
		it.terminal = 2'(t);
		it.row = 5'(r);
		it.column = 7'(c);
		it.char_byte = 8'($urandom);
		it.last_of_write = 1'($urandom_range(1));
		send(it);
	endtask

	task random_escape(int t);
		int k;
		feed(t, ESC_BYTE);
		feed(t, LBRACKET);
		k = $urandom_range(5);
		case (k)
			0: feed_text(t, $sformatf("%0dm", $urandom_range(0, 40)));
			1: feed_text(t, "2J");
			2: feed_text(t, $sformatf("%0d;%0dH", $urandom_range(0, 30),
				$urandom_range(0, 90)));
			3: feed_text(t, $sformatf("%0dJ", $urandom_range(0, 3)));
			4: feed(t, 8'($urandom));
			default: feed_text(t, $sformatf("%0d", $urandom_range(0, 9)));
		endcase
	endtask

	initial begin
		int t;
		int n;
		board = new();
		board.reset_all();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		calm = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, escapes, special cases
		read_cell(0, 0, 0);
		read_cell(3, 24, 79);
		read_cell(1, 31, 127);
		read_cell(2, 25, 80);
		feed(0, CH_BS);
		feed_text(0, "AB\x09");
		feed(0, 8'hFF);
		feed(0, 8'h00);
		feed(0, CH_CR);
		feed(0, CH_NL);
		feed(1, ESC_BYTE);
		feed(1, ESC_BYTE);
		feed_text(1, "\x1b[31m");
		feed_text(1, "\x1b[0m");
		feed_text(1, "\x1b[99999999m");
		feed_text(2, "\x1b[25;80H");
		feed_text(2, "\x1b[;H");
		feed_text(2, "\x1b[37mZ\x1b[2J");
		feed_text(3, "\x1b[25;80HQRS");
		feed_text(3, "\x1b[1;1H");
		feed(3, CH_BS);
		read_cell(3, 23, 79);

		// random traffic, mostly well-formed text and escapes
		n = 0;
		while (n < 1250) begin
			calm = (n >= 500 && n < 650);
			t = $urandom_range(TERMS - 1);
			case ($urandom_range(9))
				0, 1: begin read_cell(t, $urandom_range(31), $urandom_range(127)); n++; end
				2, 3: begin random_escape(t); n += 4; end
				4: begin feed(t, $urandom_range(3) == 0 ? CH_BS : CH_NL); n++; end
				5: begin feed(t, 8'($urandom)); n++; end
				default: begin
					read_cell(t, board.crow[t], board.ccol[t]);
					feed(t, 8'($urandom_range(8'h21, 8'h7E)));
					n += 2;
				end
			endcase
		end
		in_valid <= 1'b0;
		calm = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
